@@ sv/pist_pkg.sv @@
// Package for the point-in-shape test core: widths, codes, state type and helpers.
// Depends on nothing; every other file of the block imports it.
package pist_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 5;
    localparam int RADIUS_W     = 31;
    localparam int MUL_W        = COORD_BITS + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_SHAPE_KIND    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CIRCLE_RADIUS = 3'd4;

    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_QUERY     = 1'b1;
    localparam logic SHAPE_POLYGON = 1'b0;
    localparam logic SHAPE_CIRCLE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_DX,
        ST_C_DY,
        ST_C_RR,
        ST_C_CMP,
        ST_P_PRIME,
        ST_P_PREV,
        ST_P_LHS,
        ST_P_RHS,
        ST_P_CMP,
        ST_DONE
    } t_state;

    // Request bundle from the sequencer to the vertex store.
    typedef struct packed {
        logic                         we;
        logic [VIDX_W-1:0]            waddr;
        logic signed [COORD_BITS-1:0] wx;
        logic signed [COORD_BITS-1:0] wy;
        logic                         re;
        logic [VIDX_W-1:0]            raddr;
    } t_store_req;

    // Sign-extends a coordinate to the multiplier operand width.
    function automatic logic signed [MUL_W-1:0] ext_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        return MUL_W'(v);
    endfunction

endpackage

@@ sv/pist_in_if.sv @@
// Input channel of the point-in-shape test core: valid/ready plus one load or query item.
// Depends on pist_pkg for the field widths.
interface pist_in_if import pist_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [VIDX_W-1:0]            vertex_slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, action, vertex_slot, coord_x, coord_y, input ready);
    modport sink   (input valid, action, vertex_slot, coord_x, coord_y, output ready);
endinterface

@@ sv/pist_out_if.sv @@
// Result channel of the point-in-shape test core: valid/ready plus the inside flag.
// Depends on pist_pkg only by convention; carries a single flag bit.
interface pist_out_if import pist_pkg::*; ();
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

@@ sv/pist_vstore.sv @@
// Vertex store: one write port and one read port with registered read data.
// Depends on pist_pkg for t_store_req and the store geometry.
module pist_vstore import pist_pkg::*; (
    input  logic                         i_clk,
    input  t_store_req                   i_req,
    output logic signed [COORD_BITS-1:0] o_rx,
    output logic signed [COORD_BITS-1:0] o_ry
);

    logic signed [COORD_BITS-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_mem_y [MAX_VERTICES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem_x[i_req.waddr] <= i_req.wx;
            r_mem_y[i_req.waddr] <= i_req.wy;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rx <= r_mem_x[i_req.raddr];
            o_ry <= r_mem_y[i_req.raddr];
        end
    end

endmodule

@@ sv/pist_mul.sv @@
// Shared signed multiplier with a registered product, reused for every product of a query.
// Depends on pist_pkg for the operand and product widths.
module pist_mul import pist_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ sv/point_in_shape_test_core.sv @@
// Point-in-shape test core: polygon crossing-number test or circle test, one shared multiplier.
// Sequence: a load is written to the store on its transfer; a circle query steps through C_DX,
// C_DY, C_RR and C_CMP, a polygon query over n vertices through P_PRIME, P_PREV, then P_LHS,
// P_RHS, P_CMP per edge (straight to DONE for n = 0). Loads are taken every cycle while idle;
// a query blocks the input until it leaves DONE; it waits there while a result is still pending.
// Reset: synchronous, active low, clears sequencer, result and config; the store is not cleared.
module point_in_shape_test_core import pist_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pist_in_if.sink              i_item,
    pist_out_if.source           o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The APB port never stalls, so a write
    // lands on the access cycle. The word index is paddr[4:2].
    // ------------------------------------------------------------------
    logic                         r_shape_kind;
    logic [CNT_W-1:0]             r_vertex_count;
    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic [RADIUS_W-1:0]          r_radius;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_kind   <= SHAPE_POLYGON;
            r_vertex_count <= '0;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_radius       <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SHAPE_KIND:    r_shape_kind   <= pwdata[0];
                REG_VERTEX_COUNT:  r_vertex_count <= pwdata[CNT_W-1:0];
                REG_CENTER_X:      r_center_x     <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:      r_center_y     <= pwdata[COORD_BITS-1:0];
                REG_CIRCLE_RADIUS: r_radius       <= pwdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SHAPE_KIND:    prdata = PDATA_W'(r_shape_kind);
            REG_VERTEX_COUNT:  prdata = PDATA_W'(r_vertex_count);
            REG_CENTER_X:      prdata = PDATA_W'(unsigned'(r_center_x));
            REG_CENTER_Y:      prdata = PDATA_W'(unsigned'(r_center_y));
            REG_CIRCLE_RADIUS: prdata = PDATA_W'(r_radius);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers.
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic signed [COORD_BITS-1:0] r_x2;     // previous vertex of the current edge
    logic signed [COORD_BITS-1:0] r_y2;
    logic [VIDX_W-1:0]            r_idx;    // current vertex of the current edge
    logic [VIDX_W-1:0]            r_last;   // index of the last vertex in use
    logic                         r_cross;  // edge straddles the point's y
    logic                         r_dye_pos;
    logic signed [PROD_W-1:0]     r_lhs;
    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_inside;
    logic                         r_out_valid;
    logic                         r_out_data;

    logic                         in_acc;
    logic                         is_query;
    logic                         out_free;
    logic [CNT_W-1:0]             vcount_sat;
    logic [VIDX_W-1:0]            n_last;
    logic                         hit;

    t_store_req                   store_req;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]     prod;

    assign in_acc   = i_item.valid && i_item.ready;
    assign is_query = (i_item.action == ACT_QUERY);
    assign out_free = !r_out_valid || o_result.ready;

    // A vertex count above the store depth uses the whole store.
    assign vcount_sat = (r_vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                               : r_vertex_count;
    assign n_last     = VIDX_W'(vcount_sat - 1'b1);

    // The crossing abscissa compare, with its sense set by the sign of the edge height.
    assign hit = r_dye_pos ? (r_lhs < prod) : (prod < r_lhs);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    if (r_shape_kind == SHAPE_CIRCLE) begin
                        n_state = ST_C_DX;
                    end else if (vcount_sat == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_P_PRIME;
                    end
                end
            end
            ST_C_DX:    n_state = ST_C_DY;
            ST_C_DY:    n_state = ST_C_RR;
            ST_C_RR:    n_state = ST_C_CMP;
            ST_C_CMP:   n_state = ST_DONE;
            ST_P_PRIME: n_state = ST_P_PREV;
            ST_P_PREV:  n_state = ST_P_LHS;
            ST_P_LHS:   n_state = ST_P_RHS;
            ST_P_RHS:   n_state = ST_P_CMP;
            ST_P_CMP:   n_state = (r_idx == r_last) ? ST_DONE : ST_P_LHS;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Output logic: handshake, store requests and multiplier operand selection.
    // Each polygon edge pairs vertex r_idx (store read data) with the previous
    // vertex held in r_x2/r_y2; the walk starts with the last vertex primed.
    always_comb begin
        i_item.ready    = (r_state == ST_IDLE);
        store_req.we    = in_acc && !is_query;
        store_req.waddr = i_item.vertex_slot;
        store_req.wx    = i_item.coord_x;
        store_req.wy    = i_item.coord_y;
        store_req.re    = 1'b0;
        store_req.raddr = '0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            ST_C_DX: begin
                mul_a = ext_coord(r_px) - ext_coord(r_center_x);
                mul_b = mul_a;
            end
            ST_C_DY: begin
                mul_a = ext_coord(r_py) - ext_coord(r_center_y);
                mul_b = mul_a;
            end
            ST_C_RR: begin
                mul_a = MUL_W'(r_radius);
                mul_b = MUL_W'(r_radius);
            end
            ST_P_PRIME: begin
                store_req.re    = 1'b1;
                store_req.raddr = r_last;
            end
            ST_P_PREV: begin
                store_req.re    = 1'b1;
                store_req.raddr = '0;
            end
            ST_P_LHS: begin
                mul_a = ext_coord(r_px) - ext_coord(rx);
                mul_b = ext_coord(r_y2) - ext_coord(ry);
            end
            ST_P_RHS: begin
                mul_a = ext_coord(r_x2) - ext_coord(rx);
                mul_b = ext_coord(r_py) - ext_coord(ry);
            end
            ST_P_CMP: begin
                store_req.re    = (r_idx != r_last);
                store_req.raddr = r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset; each query loads them before use.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    r_px     <= i_item.coord_x;
                    r_py     <= i_item.coord_y;
                    r_inside <= 1'b0;
                    r_last   <= n_last;
                    r_idx    <= '0;
                end
            end
            ST_C_DY:  r_acc    <= ACC_W'(prod);
            ST_C_RR:  r_acc    <= r_acc + ACC_W'(prod);
            ST_C_CMP: r_inside <= (r_acc <= ACC_W'(prod));
            ST_P_PREV: begin
                r_x2 <= rx;
                r_y2 <= ry;
            end
            ST_P_LHS: begin
                r_cross   <= (ry > r_py) != (r_y2 > r_py);
                r_dye_pos <= (r_y2 > ry);
            end
            ST_P_RHS: r_lhs <= prod;
            ST_P_CMP: begin
                if (r_cross && hit) begin
                    r_inside <= !r_inside;
                end
                r_x2  <= rx;
                r_y2  <= ry;
                r_idx <= r_idx + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_data <= r_inside;
                end
            end
            default: ;
        endcase
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.inside_res = r_out_data;

    pist_vstore u_vstore (
        .i_clk (i_clk),
        .i_req (store_req),
        .o_rx  (rx),
        .o_ry  (ry)
    );

    pist_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

endmodule

@@ sv/pist_checker.sv @@
// Port-level checker for the point-in-shape test core, attached by the bind at the end.
// Depends on pist_pkg for the action codes; sees only the top level's ports.
module pist_checker import pist_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_action,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_inside
);

    // A query keeps the block busy for at least the cycle after its transfer.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action == ACT_QUERY) |=> !i_in_ready)
        else $error("input ready right after a query transfer");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action == ACT_LOAD && !i_out_valid)
        |=> !i_out_valid)
        else $error("result appeared after a load transfer");

    // A new result only follows a busy cycle.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the input was idle");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_inside)))
        else $error("stalled result dropped or changed");

endmodule

bind point_in_shape_test_core pist_checker u_pist_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_in_action  (i_item.action),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_inside (o_result.inside_res)
);

@@ dv/tb.sv @@
// Self-checking testbench for point_in_shape_test_core: polygon crossing-number and circle tests.
// Depends on pist_pkg, the pist_in_if / pist_out_if channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb;
    import pist_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    // Wide enough for a sum of two squared 33-bit differences.
    typedef logic signed [2*COORD_BITS+3:0] t_wide;

    typedef struct packed {
        logic              action;
        logic [VIDX_W-1:0] slot;
        t_coord            x;
        t_coord            y;
    } t_item;

    localparam t_coord      COORD_MIN   = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord      COORD_MAX   = ~COORD_MIN;
    localparam t_coord      Q_ONE       = 65536;
    localparam int unsigned RADIUS_MAX  = (1 << RADIUS_W) - 1;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          HOLD_ROUND  = 2;
    localparam int          NUM_ROUNDS  = 20;
    localparam int          ROUND_ITEMS = 22;
    localparam int          LOAD_TAIL   = 4;
    localparam int          END_TAIL    = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pist_in_if  in_ch ();
    pist_out_if res_ch ();

    point_in_shape_test_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the configuration registers and of the vertex store, as the core
    // should hold them. The store mirror is updated when a load transfer happens.
    logic              cfg_shape;
    logic [CNT_W-1:0]  cfg_count;
    t_coord            cfg_cx;
    t_coord            cfg_cy;
    logic [RADIUS_W-1:0] cfg_radius;
    t_coord            vx_mirror [MAX_VERTICES];
    t_coord            vy_mirror [MAX_VERTICES];

    // Generation-time copy of the store, so that queries can aim at stored vertices.
    t_coord            gen_vx [MAX_VERTICES];
    t_coord            gen_vy [MAX_VERTICES];

    t_item             item_backlog [$];
    logic              inside_expected [$];
    t_item             offer_item;
    logic              item_taken;

    int                items_queued;
    int                items_accepted;
    int                fail_count;
    int                cycle_count;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int                hold_trigger;
    int                hold_seen;
    int                hold_left;

    // Expected inside flag for a query point under the current shadow state.
    // Circle: squared distance against squared radius, at full width, so a point
    // on the circle counts as inside. Polygon: parity of crossings, with the
    // float division replaced by a cross-multiplied compare whose sense flips
    // with the sign of the edge height.
    function automatic logic calc_inside(input t_coord px, input t_coord py);
        longint dx;
        longint dy;
        longint dye;
        t_wide  lhs;
        t_wide  rhs;
        int     n;
        int     i;
        int     j;
        logic   hit;
        logic   parity;
        if (cfg_shape == SHAPE_CIRCLE) begin
            dx  = longint'(px) - longint'(cfg_cx);
            dy  = longint'(py) - longint'(cfg_cy);
            lhs = t_wide'(dx) * t_wide'(dx) + t_wide'(dy) * t_wide'(dy);
            rhs = t_wide'(cfg_radius) * t_wide'(cfg_radius);
            return lhs <= rhs;
        end
        // Counts above the store size saturate; a count of zero gives outside.
        n = (cfg_count > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_count);
        parity = 1'b0;
        if (n == 0) begin
            return 1'b0;
        end
        j = n - 1;
        for (i = 0; i < n; i++) begin
            // A single vertex pairs with itself and never straddles the point.
            if ((vy_mirror[i] > py) != (vy_mirror[j] > py)) begin
                dye = longint'(vy_mirror[j]) - longint'(vy_mirror[i]);
                dx  = longint'(px) - longint'(vx_mirror[i]);
                lhs = t_wide'(dx) * t_wide'(dye);
                dx  = longint'(vx_mirror[j]) - longint'(vx_mirror[i]);
                dy  = longint'(py) - longint'(vy_mirror[i]);
                rhs = t_wide'(dx) * t_wide'(dy);
                hit = (dye > 0) ? (lhs < rhs) : (rhs < lhs);
                if (hit) begin
                    parity = ~parity;
                end
            end
            j = i;
        end
        return parity;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Cycle budget for the whole run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Input driver. A new item is offered at the falling edge once the previous
    // offer has been transferred; otherwise valid and the payload are held.
    always @(negedge i_clk) begin
        if (!in_ch.valid || item_taken) begin
            if (item_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                offer_item = item_backlog.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.action      <= offer_item.action;
                in_ch.vertex_slot <= offer_item.slot;
                in_ch.coord_x     <= offer_item.x;
                in_ch.coord_y     <= offer_item.y;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver. A bump of hold_trigger starts a long hold-off, counted
    // here, during which ready stays low and the core backs up into its input.
    always @(negedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen    <= hold_trigger;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor. Input transfers update the store mirror or queue an expected
    // flag; result transfers are checked against the oldest expectation.
    always @(posedge i_clk) begin
        logic want;
        item_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            items_accepted++;
            if (in_ch.action == ACT_LOAD) begin
                vx_mirror[in_ch.vertex_slot] = in_ch.coord_x;
                vy_mirror[in_ch.vertex_slot] = in_ch.coord_y;
            end else begin
                inside_expected.push_back(calc_inside(in_ch.coord_x, in_ch.coord_y));
            end
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (inside_expected.size() == 0) begin
                flag_mismatch("result transfer with no query outstanding");
            end else begin
                want = inside_expected.pop_front();
                if (res_ch.inside_res !== want) begin
                    flag_mismatch($sformatf("inside_res got %b, expected %b",
                                            res_ch.inside_res, want));
                end
            end
        end
    end

    // One register write over the configuration port: setup phase, then access
    // phase held until pready. The shadow copy follows at the write edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_SHAPE_KIND:    cfg_shape  = value[0];
            REG_VERTEX_COUNT:  cfg_count  = value[CNT_W-1:0];
            REG_CENTER_X:      cfg_cx     = value;
            REG_CENTER_Y:      cfg_cy     = value;
            REG_CIRCLE_RADIUS: cfg_radius = value[RADIUS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic kind, input int cnt, input t_coord cx,
                                input t_coord cy, input int unsigned rad);
        write_reg(REG_SHAPE_KIND, PDATA_W'(kind));
        write_reg(REG_VERTEX_COUNT, PDATA_W'(cnt));
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CIRCLE_RADIUS, PDATA_W'(rad));
    endtask

    task automatic push_item(input logic act, input logic [VIDX_W-1:0] slot,
                             input t_coord x, input t_coord y);
        t_item it;
        it.action = act;
        it.slot   = slot;
        it.x      = x;
        it.y      = y;
        item_backlog.push_back(it);
        items_queued++;
        if (act == ACT_LOAD) begin
            gen_vx[slot] = x;
            gen_vy[slot] = y;
        end
    endtask

    // Queries carry a random slot too, since the core must ignore it.
    task automatic push_query(input t_coord x, input t_coord y);
        push_item(ACT_QUERY, VIDX_W'($urandom), x, y);
    endtask

    // Waits until every item has been transferred and every flag has come back,
    // then lets the core finish any load still in flight.
    task automatic settle(input int tail);
        while (items_accepted != items_queued || inside_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (tail) @(negedge i_clk);
    endtask

    function automatic t_coord near_coord(input t_coord base, input int unsigned shift);
        return base + ($signed($urandom) >>> shift);
    endfunction

    function automatic t_coord pick_origin();
        case ($urandom_range(5, 0))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return $signed($urandom) >>> $urandom_range(12, 1);
        endcase
    endfunction

    // One random setting: write all registers, reload the polygon if there is
    // one, then a mix of well-formed queries, boundary hits and noise.
    task automatic random_round(input int round_idx);
        logic        kind;
        int          cnt;
        int          used;
        int          pick;
        int          a;
        int          b;
        int          k;
        int unsigned sh;
        int unsigned rad;
        t_coord      ox;
        t_coord      oy;
        t_coord      px;
        t_coord      py;
        longint      dx;
        longint      dy;
        kind = (round_idx == 0 || $urandom_range(99, 0) < 60) ? SHAPE_POLYGON : SHAPE_CIRCLE;
        pick = $urandom_range(9, 0);
        // The first round fills the whole store and runs with the count saturated.
        if (round_idx == 0) begin
            cnt = 31;
        end else if (pick == 0) begin
            cnt = $urandom_range(2, 0);
        end else if (pick == 1) begin
            cnt = $urandom_range(31, MAX_VERTICES + 1);
        end else begin
            cnt = $urandom_range(MAX_VERTICES, 3);
        end
        used = (round_idx == 0 || cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
        ox   = pick_origin();
        oy   = pick_origin();
        sh   = $urandom_range(28, 1);
        case ($urandom_range(9, 0))
            0:       rad = 0;
            1:       rad = RADIUS_MAX;
            default: rad = $urandom >> $urandom_range(31, 1);
        endcase
        apply_config(kind, cnt, ox, oy, rad);

        @(posedge i_clk);
        if (round_idx < NUM_ROUNDS / 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 53;
        end else if (round_idx < 2 * NUM_ROUNDS / 3) begin
            send_idle_pct = 53;
            recv_idle_pct = 23;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (round_idx == HOLD_ROUND) begin
            hold_trigger = hold_trigger + 1;
        end

        if (kind == SHAPE_POLYGON) begin
            for (k = 0; k < used; k++) begin
                px = near_coord(ox, sh);
                py = near_coord(oy, sh);
                // Shared coordinates give horizontal and vertical edges.
                if (k > 0 && $urandom_range(3, 0) == 0) begin
                    py = gen_vy[k-1];
                end else if (k > 0 && $urandom_range(3, 0) == 0) begin
                    px = gen_vx[k-1];
                end
                push_item(ACT_LOAD, VIDX_W'(k), px, py);
            end
        end

        for (k = 0; k < ROUND_ITEMS; k++) begin
            pick = $urandom_range(99, 0);
            a    = $urandom_range(MAX_VERTICES - 1, 0);
            b    = (a + 1) % MAX_VERTICES;
            if (pick < 8) begin
                push_item(ACT_LOAD, VIDX_W'($urandom), t_coord'($urandom), t_coord'($urandom));
            end else if (pick < 16) begin
                push_query(t_coord'($urandom), t_coord'($urandom));
            end else if (kind == SHAPE_CIRCLE) begin
                dx = longint'($urandom_range(rad, 0));
                dy = longint'($urandom_range(rad, 0));
                if (pick < 28) begin
                    // Exactly on the circle, along an axis.
                    dx = rad;
                    dy = 0;
                end
                if ($urandom_range(1, 0) == 1) begin
                    dx = -dx;
                end
                if ($urandom_range(1, 0) == 1) begin
                    dy = -dy;
                end
                if ($urandom_range(1, 0) == 1) begin
                    push_query(ox + t_coord'(dx), oy + t_coord'(dy));
                end else begin
                    push_query(ox + t_coord'(dy), oy + t_coord'(dx));
                end
            end else if (pick < 28) begin
                push_query(gen_vx[a], gen_vy[a]);
            end else if (pick < 40) begin
                push_query(near_coord(ox, sh), gen_vy[a]);
            end else if (pick < 50) begin
                push_query(t_coord'((longint'(gen_vx[a]) + longint'(gen_vx[b])) >>> 1),
                           t_coord'((longint'(gen_vy[a]) + longint'(gen_vy[b])) >>> 1));
            end else begin
                push_query(near_coord(ox, sh), near_coord(oy, sh));
            end
        end
        settle(LOAD_TAIL);
    endtask

    initial begin
        int r;
        // Every input of the core is known from time zero.
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_LOAD;
        in_ch.vertex_slot = '0;
        in_ch.coord_x     = '0;
        in_ch.coord_y     = '0;
        res_ch.ready      = 1'b0;
        item_taken        = 1'b0;
        items_queued      = 0;
        items_accepted    = 0;
        fail_count        = 0;
        cycle_count       = 0;
        send_idle_pct     = 23;
        recv_idle_pct     = 53;
        hold_trigger      = 0;
        hold_seen         = 0;
        hold_left         = 0;
        cfg_shape         = SHAPE_POLYGON;
        cfg_count         = '0;
        cfg_cx            = '0;
        cfg_cy            = '0;
        cfg_radius        = '0;
        for (r = 0; r < MAX_VERTICES; r++) begin
            vx_mirror[r] = '0;
            vy_mirror[r] = '0;
            gen_vx[r]    = '0;
            gen_vy[r]    = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Out of reset the core runs a polygon test with a count
        // of zero, so the first query must come back outside without reading
        // the store. Then a square with corners at plus and minus Q_ONE goes into slots 0 to 3,
        // and the top slot gets the extreme coordinates.
        @(posedge i_clk);
        push_query(COORD_MAX, COORD_MIN);
        push_item(ACT_LOAD, 0, -Q_ONE, -Q_ONE);
        push_item(ACT_LOAD, 1,  Q_ONE, -Q_ONE);
        push_item(ACT_LOAD, 2,  Q_ONE,  Q_ONE);
        push_item(ACT_LOAD, 3, -Q_ONE,  Q_ONE);
        push_item(ACT_LOAD, VIDX_W'(MAX_VERTICES - 1), COORD_MIN, COORD_MAX);
        settle(LOAD_TAIL);

        // Square: center, each side, outside and a far corner of the plane.
        apply_config(SHAPE_POLYGON, 4, 0, 0, 0);
        @(posedge i_clk);
        push_query(0, 0);
        push_query(Q_ONE, 0);
        push_query(-Q_ONE, 0);
        push_query(0, Q_ONE);
        push_query(0, -Q_ONE);
        push_query(2 * Q_ONE, 0);
        push_query(COORD_MIN, COORD_MIN);
        settle(LOAD_TAIL);

        // A single vertex has only a degenerate edge and is never crossed.
        apply_config(SHAPE_POLYGON, 1, 0, 0, 0);
        @(posedge i_clk);
        push_query(-2 * Q_ONE, -Q_ONE);
        push_query(-Q_ONE, -Q_ONE);
        settle(LOAD_TAIL);

        // Unit circle at the origin: on the circle is inside, one step out is not.
        apply_config(SHAPE_CIRCLE, 4, 0, 0, Q_ONE);
        @(posedge i_clk);
        push_query(Q_ONE, 0);
        push_query(Q_ONE + 1, 0);
        push_query(0, -Q_ONE);
        push_query(Q_ONE / 2, Q_ONE / 2);
        settle(LOAD_TAIL);

        // Extreme center and largest radius; the farthest point overflows any
        // narrow datapath. A load in circle mode must not disturb the flag.
        apply_config(SHAPE_CIRCLE, 4, COORD_MIN, COORD_MAX, RADIUS_MAX);
        @(posedge i_clk);
        push_query(COORD_MIN, COORD_MAX);
        push_query(COORD_MAX, COORD_MIN);
        push_item(ACT_LOAD, 7, COORD_MAX, COORD_MAX);
        push_query(0, 0);
        settle(LOAD_TAIL);

        // Zero radius: only the center itself is inside.
        apply_config(SHAPE_CIRCLE, 0, COORD_MAX, COORD_MIN, 0);
        @(posedge i_clk);
        push_query(COORD_MAX, COORD_MIN);
        push_query(COORD_MAX, COORD_MIN + 1);
        settle(LOAD_TAIL);

        // Random part, one configuration per round.
        for (r = 0; r < NUM_ROUNDS; r++) begin
            random_round(r);
        end

        settle(END_TAIL);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
